// ===== design/fdrle_pkg.sv =====
package fdrle_pkg;

    // opcodes of the coded stream
    localparam logic [7:0] OP_END       = 8'h00;
    localparam logic [7:0] OP_END_ALT   = 8'h13;
    localparam logic [7:0] OP_SKIP_ONE  = 8'h02;
    localparam logic [7:0] OP_SKIP_B    = 8'h03;
    localparam logic [7:0] OP_SKIP_W    = 8'h04;
    localparam logic [7:0] OP_LIT_FIRST = 8'h06;
    localparam logic [7:0] OP_LIT_LAST  = 8'h0a;
    localparam logic [7:0] OP_LIT_B     = 8'h0b;
    localparam logic [7:0] OP_LIT_W     = 8'h0c;
    localparam logic [7:0] OP_FILL_FIRST = 8'h0d;
    localparam logic [7:0] OP_FILL_LAST = 8'h10;
    localparam logic [7:0] OP_FILL_B    = 8'h11;
    localparam logic [7:0] OP_FILL_W    = 8'h12;

    // count bias of the short opcodes
    localparam logic [7:0] LIT_BIAS  = 8'h05;
    localparam logic [7:0] FILL_BIAS = 8'h0b;

    localparam logic [15:0] FRAME_WORDS_RST = 16'd32000;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_END   = 1'b1;

    typedef enum logic [4:0] {
        PH_OP     = 5'b00001,
        PH_CNT_LO = 5'b00010,
        PH_CNT_HI = 5'b00100,
        PH_VAL_LO = 5'b01000,
        PH_VAL_HI = 5'b10000
    } t_phase;

    typedef struct packed {
        logic        kind;
        logic [14:0] word_addr;
        logic [16:0] run_count;
        logic [15:0] run_value;
        logic        overrun;
    } t_result;

endpackage

// ===== design/fdrle_in_stage.sv =====
module fdrle_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic       i_drain,
    output logic       o_fire,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    // the held byte moves on whenever the result side has room
    assign o_fire        = r_valid && i_drain;
    assign s_axis_tready = !r_valid || i_drain;
    assign o_byte        = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_byte <= s_axis_tdata;
        end
    end

endmodule

// ===== design/fdrle_parser.sv =====
module fdrle_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_byte,
    input  logic [15:0]      i_limit,
    output logic             o_res_valid,
    output fdrle_pkg::t_result o_res
);

    import fdrle_pkg::*;

    t_phase      r_phase,    n_phase;
    logic [4:0]  r_opcode,   n_opcode;
    logic [7:0]  r_low_byte, n_low_byte;
    logic [16:0] r_count,    n_count;
    logic [16:0] r_lit_left, n_lit_left;
    logic [15:0] r_word_ptr, n_word_ptr;
    logic        r_overrun,  n_overrun;

    logic [7:0]  op8;
    logic [15:0] operand;
    logic [16:0] cnt_short;
    logic [16:0] cnt_long;
    logic [16:0] lit_dec;
    logic        is_lit_op;

    // shared advance / write unit controls
    logic        adv_en;
    logic        wr_en;
    logic        end_en;
    logic [16:0] adv_n;
    logic        ptr_in;
    logic [15:0] room;
    logic        over;

    assign op8       = {3'b000, r_opcode};
    assign operand   = {i_byte, r_low_byte};
    assign cnt_short = {9'd0, i_byte} + 17'd1;
    assign cnt_long  = {1'b0, operand} + 17'd1;
    assign lit_dec   = r_lit_left - 17'd1;
    assign is_lit_op = (op8 >= OP_LIT_FIRST) && (op8 <= OP_LIT_W);

    // decode of one byte against the parser phase
    always_comb begin
        n_phase    = r_phase;
        n_opcode   = r_opcode;
        n_low_byte = r_low_byte;
        n_count    = r_count;
        n_lit_left = r_lit_left;
        adv_en     = 1'b0;
        wr_en      = 1'b0;
        end_en     = 1'b0;
        adv_n      = 17'd1;
        case (r_phase)
            PH_CNT_LO: begin
                if (op8 == OP_SKIP_B || op8 == OP_LIT_B || op8 == OP_FILL_B) begin
                    if (op8 == OP_SKIP_B) begin
                        adv_en  = 1'b1;
                        adv_n   = cnt_short;
                        n_phase = PH_OP;
                    end else begin
                        n_lit_left = cnt_short;
                        n_count    = cnt_short;
                        n_phase    = PH_VAL_LO;
                    end
                end else begin
                    n_low_byte = i_byte;
                    n_phase    = PH_CNT_HI;
                end
            end
            PH_CNT_HI: begin
                if (op8 == OP_SKIP_W) begin
                    adv_en  = 1'b1;
                    adv_n   = cnt_long;
                    n_phase = PH_OP;
                end else begin
                    n_lit_left = cnt_long;
                    n_count    = cnt_long;
                    n_phase    = PH_VAL_LO;
                end
            end
            PH_VAL_LO: begin
                n_low_byte = i_byte;
                n_phase    = PH_VAL_HI;
            end
            PH_VAL_HI: begin
                adv_en = 1'b1;
                wr_en  = 1'b1;
                if (is_lit_op) begin
                    adv_n      = 17'd1;
                    n_lit_left = lit_dec;
                    n_phase    = (lit_dec == 17'd0) ? PH_OP : PH_VAL_LO;
                end else begin
                    adv_n   = r_count;
                    n_phase = PH_OP;
                end
            end
            default: begin
                n_phase  = PH_OP;
                n_opcode = i_byte[4:0];
                if (i_byte == OP_END || i_byte == OP_END_ALT) begin
                    end_en = 1'b1;
                end else if (i_byte == OP_SKIP_ONE) begin
                    adv_en = 1'b1;
                end else if (i_byte == OP_SKIP_B || i_byte == OP_SKIP_W ||
                             i_byte == OP_LIT_B || i_byte == OP_LIT_W ||
                             i_byte == OP_FILL_B || i_byte == OP_FILL_W) begin
                    n_phase = PH_CNT_LO;
                end else if (i_byte >= OP_LIT_FIRST && i_byte <= OP_LIT_LAST) begin
                    n_lit_left = {9'd0, i_byte - LIT_BIAS};
                    n_phase    = PH_VAL_LO;
                end else if (i_byte >= OP_FILL_FIRST && i_byte <= OP_FILL_LAST) begin
                    n_count = {9'd0, i_byte - FILL_BIAS};
                    n_phase = PH_VAL_LO;
                end
            end
        endcase
    end

    // pointer advance with clipping at the frame limit
    assign ptr_in = r_word_ptr < i_limit;
    assign room   = ptr_in ? (i_limit - r_word_ptr) : 16'd0;
    assign over   = adv_n > {1'b0, room};

    always_comb begin
        n_word_ptr = r_word_ptr;
        n_overrun  = r_overrun;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (end_en) begin
            o_res_valid   = 1'b1;
            o_res.kind    = KIND_END;
            o_res.overrun = r_overrun;
            n_word_ptr    = 16'd0;
            n_overrun     = 1'b0;
        end else if (adv_en) begin
            if (over) begin
                n_overrun  = 1'b1;
                n_word_ptr = ptr_in ? i_limit : r_word_ptr;
            end else begin
                n_word_ptr = r_word_ptr + adv_n[15:0];
            end
            if (wr_en && ptr_in) begin
                o_res_valid     = 1'b1;
                o_res.kind      = KIND_WRITE;
                o_res.word_addr = r_word_ptr[14:0];
                o_res.run_count = over ? {1'b0, room} : adv_n;
                o_res.run_value = operand;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_OP;
            r_opcode   <= 5'd0;
            r_low_byte <= 8'd0;
            r_count    <= 17'd0;
            r_lit_left <= 17'd0;
            r_word_ptr <= 16'd0;
            r_overrun  <= 1'b0;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_opcode   <= n_opcode;
            r_low_byte <= n_low_byte;
            r_count    <= n_count;
            r_lit_left <= n_lit_left;
            r_word_ptr <= n_word_ptr;
            r_overrun  <= n_overrun;
        end
    end

endmodule

// ===== design/fdrle_out_stage.sv =====
module fdrle_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic               i_res_valid,
    input  fdrle_pkg::t_result i_res,
    output logic               o_drain,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [55:0]        m_axis_tdata,
    output logic [0:0]         m_axis_tuser
);

    import fdrle_pkg::*;

    logic    r_valid;
    t_result r_res;

    // room for a new result: empty, or the held one leaves this cycle
    assign o_drain       = !r_valid || m_axis_tready;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tuser  = r_res.kind;
    assign m_axis_tdata  = {7'd0, r_res.overrun, r_res.run_value,
                            r_res.run_count, r_res.word_addr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_fire && i_res_valid) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== design/frame_delta_rle_decoder_top.sv =====
// channel   | dir | tdata (lsb first)                                  | tuser
// ----------+-----+----------------------------------------------------+-----------
// s_axis    | in  | in_byte[7:0]                                       | -
// m_axis    | out | word_addr[14:0] run_count[16:0] run_value[15:0]    | kind[0]
//           |     | overrun[1] zero pad to 56 bits                     |
// cfg       | in  | i_cfg_wr_en / i_cfg_wr_data = frame_words[15:0]    | -
//
// one byte per cycle sustained while m_axis accepts; each byte is held in the input register,
// the parser decodes it combinationally and its result is registered into the output register
// at the same edge that moves the parser state on
// the parser state update (subtract, compare and add on the word pointer) sets the cycle
// synchronous active-low reset clears parser state, pointer, overrun flag and sets
// frame_words to 32000
// a stalled m_axis holds the output register; the input register then holds its byte
module frame_delta_rle_decoder_top #(
    parameter int MAX_FRAME_WORDS = 32768
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: frame_words
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    // coded byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte[7:0]
    // run / end-of-frame results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // word_addr, run_count, run_value, overrun
    output logic [0:0]  m_axis_tuser    // kind
);

    import fdrle_pkg::*;

    localparam logic [16:0] MAX_WORDS = 17'(MAX_FRAME_WORDS);

    logic [15:0] r_frame_words;
    logic [15:0] limit;
    logic        drain;
    logic        fire;
    logic [7:0]  byte_q;
    logic        res_valid;
    t_result     res;

    // frame_words register, to be written only while no byte is in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_words <= FRAME_WORDS_RST;
        end else if (i_cfg_wr_en) begin
            r_frame_words <= i_cfg_wr_data;
        end
    end

    // effective limit: frame_words capped at the largest frame
    assign limit = ({1'b0, r_frame_words} > MAX_WORDS) ? MAX_WORDS[15:0] : r_frame_words;

    fdrle_in_stage u_in (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_drain       (drain),
        .o_fire        (fire),
        .o_byte        (byte_q)
    );

    fdrle_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_byte      (byte_q),
        .i_limit     (limit),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    fdrle_out_stage u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_res_valid   (res_valid),
        .i_res         (res),
        .o_drain       (drain),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
